[hdl/utf8d_pkg.sv]
// utf8d_pkg: shared constants and types for the utf8 decoder
// used by the channel interfaces, the decode core and the top level

package utf8d_pkg;

  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned PEND_W  = 2;

  localparam logic [BYTE_W-1:0] LEAD_1B_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_2B_LIMIT = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_3B_LIMIT = 8'hF0;

  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h3F;
  localparam logic [BYTE_W-1:0] LEAD_2B_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD_3B_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD_4B_MASK = 8'h07;

  localparam logic [PEND_W-1:0] PEND_2B = 2'd1;
  localparam logic [PEND_W-1:0] PEND_3B = 2'd2;
  localparam logic [PEND_W-1:0] PEND_4B = 2'd3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic               end_of_string;
    logic [TOTAL_W-1:0] char_total;
  } utf8d_res_t;

endpackage

[hdl/utf8d_byte_if.sv]
// utf8d_byte_if: valid/ready channel carrying one text byte per transfer
// depends on utf8d_pkg

interface utf8d_byte_if;
  import utf8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

[hdl/utf8d_res_if.sv]
// utf8d_res_if: valid/ready channel carrying one decoded result per transfer
// depends on utf8d_pkg

interface utf8d_res_if;
  import utf8d_pkg::*;

  logic               valid;
  logic               ready;
  logic [CP_W-1:0]    code_point;
  logic               end_of_string;
  logic [TOTAL_W-1:0] char_total;

  modport source (output valid, output code_point, output end_of_string,
                  output char_total, input ready);
  modport sink   (input valid, input code_point, input end_of_string,
                  input char_total, output ready);
endinterface

[hdl/utf8d_core.sv]
// utf8d_core: decoder state (pending count, partial code point, char count)
// and the per-byte update logic; depends on utf8d_pkg

module utf8d_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [utf8d_pkg::BYTE_W-1:0] text_byte_i,
  output logic                         emit_o,
  output utf8d_pkg::utf8d_res_t        res_o
);
  import utf8d_pkg::*;

  localparam int unsigned EXT_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [PEND_W-1:0]     pend_q, pend_d;
  logic [CP_W-1:0]       part_q, part_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [EXT_W-1:0]      cnt_ext;
  logic                  emit_char;
  logic                  emit_end;

  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    pend_d    = pend_q;
    part_d    = part_q;
    cnt_d     = cnt_q;
    emit_char = 1'b0;
    emit_end  = 1'b0;
    if (pend_q != '0) begin
      part_d = {part_q[CP_W-7:0], text_byte_i[5:0]};
      pend_d = pend_q - 1'b1;
      if (pend_q == PEND_2B) begin
        emit_char = 1'b1;
        cnt_d     = cnt_inc;
      end
    end else if (text_byte_i == '0) begin
      emit_end = 1'b1;
      part_d   = '0;
      cnt_d    = '0;
    end else if (text_byte_i < LEAD_1B_LIMIT) begin
      part_d    = CP_W'(text_byte_i);
      emit_char = 1'b1;
      cnt_d     = cnt_inc;
    end else if (text_byte_i < LEAD_2B_LIMIT) begin
      part_d = CP_W'(text_byte_i & LEAD_2B_MASK);
      pend_d = PEND_2B;
    end else if (text_byte_i < LEAD_3B_LIMIT) begin
      part_d = CP_W'(text_byte_i & LEAD_3B_MASK);
      pend_d = PEND_3B;
    end else begin
      part_d = CP_W'(text_byte_i & LEAD_4B_MASK);
      pend_d = PEND_4B;
    end
  end

  // end result reports the count before clearing, a char result the count after
  assign cnt_ext = emit_end ? EXT_W'(cnt_q) : EXT_W'(cnt_d);

  always_comb begin
    emit_o              = emit_char | emit_end;
    res_o.code_point    = emit_end ? '0 : part_d;
    res_o.end_of_string = emit_end;
    res_o.char_total    = (cnt_ext > EXT_W'(TOTAL_MAX)) ? TOTAL_MAX : cnt_ext[TOTAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      part_q <= '0;
      cnt_q  <= '0;
    end else if (step_i) begin
      pend_q <= pend_d;
      part_q <= part_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[hdl/utf8_decoder.sv]
// utf8_decoder: streaming utf8 to code point decoder, top level
// depends on utf8d_pkg, utf8d_byte_if, utf8d_res_if and utf8d_core
//
// byte_i takes one raw text byte per transfer (valid/ready). res_o gives a
// result for each completed code point and one end result (end_of_string
// high, code_point zero, char_total = string total) for a zero lead byte.
// Bytes of a multi-byte sequence other than the last give no result.
// A byte is held in an input register, decoded from there and its result
// loaded into the output register, which drives res_o. One byte per cycle
// is sustained while res_o is not stalled; the rate is set by the single
// decode step between the two registers.
// When res_o is stalled with a result held, the input register still
// drains bytes that give no result; a byte that gives a result waits, and
// byte_i drops ready once the input register is full.
// Reset clears the pending count, partial value and character count, and
// empties both registers.

module utf8_decoder (
  input  logic   clk_i,
  input  logic   rst_ni,
  utf8d_byte_if.sink  byte_i,
  utf8d_res_if.source res_o
);
  import utf8d_pkg::*;

  logic              in_vld_q, in_vld_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              out_vld_q, out_vld_d;
  utf8d_res_t        out_res_q;
  utf8d_res_t        core_res;
  logic              core_emit;
  logic              out_free;
  logic              step;

  assign out_free = ~out_vld_q | res_o.ready;
  assign step     = in_vld_q & (out_free | ~core_emit);

  assign byte_i.ready = ~in_vld_q | step;

  utf8d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .text_byte_i (in_byte_q),
    .emit_o      (core_emit),
    .res_o       (core_res)
  );

  always_comb begin
    in_vld_d = byte_i.ready ? byte_i.valid : in_vld_q;
    if (step && core_emit) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q <= byte_i.text_byte;
    end
    if (step && core_emit) begin
      out_res_q <= core_res;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.code_point    = out_res_q.code_point;
  assign res_o.end_of_string = out_res_q.end_of_string;
  assign res_o.char_total    = out_res_q.char_total;

endmodule

[hdl/utf8d_checker.sv]
// utf8d_checker: port-level checks on the utf8 decoder result channel
// depends on utf8d_pkg; bound to utf8_decoder below

module utf8d_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [utf8d_pkg::CP_W-1:0]    code_point_i,
  input logic                          end_of_string_i,
  input logic [utf8d_pkg::TOTAL_W-1:0] char_total_i
);
  import utf8d_pkg::*;

  logic               res_xfer;
  logic               prev_end_q;
  logic [TOTAL_W-1:0] prev_total_q;

  assign res_xfer = res_valid_i & res_ready_i;

  // previous result transfer, starting as if a string had just ended
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_end_q   <= 1'b1;
      prev_total_q <= '0;
    end else if (res_xfer) begin
      prev_end_q   <= end_of_string_i;
      prev_total_q <= char_total_i;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(code_point_i)
      && $stable(end_of_string_i) && $stable(char_total_i))
    else $error("result changed while stalled");

  a_end_zero_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && end_of_string_i |-> code_point_i == '0)
    else $error("end result with nonzero code point");

  a_first_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_xfer && !end_of_string_i && prev_end_q |-> char_total_i == TOTAL_W'(1))
    else $error("first character of a string not counted as one");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_xfer && !prev_end_q |-> char_total_i == prev_total_q + 1'b1
      || (char_total_i == prev_total_q && char_total_i == TOTAL_MAX)
      || end_of_string_i && char_total_i == prev_total_q)
    else $error("character count out of step");

endmodule

bind utf8_decoder utf8d_checker u_utf8d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .code_point_i    (res_o.code_point),
  .end_of_string_i (res_o.end_of_string),
  .char_total_i    (res_o.char_total)
);
